### hw/rtl/rpts_pkg.sv
// ----------------------------------------------------------------------------
// Thread scheduler package
// Shared constants, codes, request and status types, and the priority lookup.
// ----------------------------------------------------------------------------
package rpts_pkg;

  localparam int MAX_THREADS   = 8;
  localparam int PRIORITY_BITS = 8;
  localparam int TIDX_W        = 3;
  localparam int CNT_W         = $clog2(MAX_THREADS + 1);
  localparam int TC_W          = 4;
  localparam int PRIO_TABLE_W  = 64;
  localparam int MS_W          = 32;
  localparam int FUNC_W        = 3;
  localparam int STATE_W       = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int FIFO_DEPTH    = 2;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int FCNT_W        = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [STATE_W-1:0] {
    ST_ACTIVE   = 3'd0,
    ST_PAUSED   = 3'd1,
    ST_QUEUED   = 3'd2,
    ST_WAITING  = 3'd3,
    ST_SLEEPING = 3'd4,
    ST_BLOCKED  = 3'd5
  } thread_state_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK      = 3'd0,
    FN_BLOCK_CUR = 3'd1,
    FN_BLOCK_IDX = 3'd2,
    FN_UNBLOCK   = 3'd3,
    FN_SLEEP     = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_BLOCK_CUR,
    OP_BLOCK_IDX,
    OP_UNBLOCK,
    OP_SLEEP
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_COUNT  = 2'd1,
    CFG_PRIO   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_APPLY,
    BK_WAKE,
    BK_PAUSE,
    BK_SELECT,
    BK_COMMIT,
    BK_REPORT
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic              sw;
    logic [TIDX_W-1:0] idx;
    logic [MS_W-1:0]   ms;
    logic [CNT_W-1:0]  n;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [PRIORITY_BITS-1:0] prio_of(
    input logic [PRIO_TABLE_W-1:0] tbl,
    input logic [TIDX_W-1:0]       idx
  );
    int unsigned             sh;
    logic [PRIO_TABLE_W-1:0] shifted;
    sh      = int'(idx) * PRIORITY_BITS;
    shifted = tbl >> sh;
    if (sh >= PRIO_TABLE_W) begin
      return '0;
    end
    return shifted[PRIORITY_BITS-1:0];
  endfunction

endpackage

### hw/rtl/rpts_req_if.sv
// ----------------------------------------------------------------------------
// Event request channel
// Valid/ready channel carrying one scheduler event.
// ----------------------------------------------------------------------------
interface rpts_req_if import rpts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TIDX_W-1:0] thread_index;
  logic [MS_W-1:0]   sleep_ms;

  modport source(output valid, func, thread_index, sleep_ms, input ready);
  modport sink(input valid, func, thread_index, sleep_ms, output ready);
endinterface

### hw/rtl/rpts_rsp_if.sv
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying the running thread after each request.
// ----------------------------------------------------------------------------
interface rpts_rsp_if import rpts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIDX_W-1:0]  current_thread;
  logic [STATE_W-1:0] current_state;
  logic               switched;

  modport source(output valid, current_thread, current_state, switched, input ready);
  modport sink(input valid, current_thread, current_state, switched, output ready);
endinterface

### hw/rtl/rpts_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rpts_cfg_if import rpts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/rpts_front.sv
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts event requests, checks the addressed thread and decodes each
// request into a command for the command queue.
// ----------------------------------------------------------------------------
module rpts_front import rpts_pkg::*; (
  rpts_req_if.sink          req,
  input  logic              enabled,
  input  logic [TC_W-1:0]   thread_count,
  input  fifo_status_t      fifo_st,
  output logic              push,
  output cmd_t              cmd
);

  logic [CNT_W-1:0] n;
  logic             idx_ok;

  always_comb begin
    if (thread_count == '0) begin
      n = CNT_W'(1);
    end else if (int'(thread_count) > MAX_THREADS) begin
      n = CNT_W'(MAX_THREADS);
    end else begin
      n = CNT_W'(thread_count);
    end
  end

  assign idx_ok = CNT_W'(req.thread_index) < n;

  always_comb begin
    cmd.op  = OP_NOP;
    cmd.sw  = 1'b0;
    cmd.idx = req.thread_index;
    cmd.ms  = req.sleep_ms;
    cmd.n   = n;
    case (req.func)
      FN_TICK: begin
        cmd.op = OP_TICK;
        cmd.sw = enabled;
      end
      FN_BLOCK_CUR: begin
        cmd.op = OP_BLOCK_CUR;
        cmd.sw = 1'b1;
      end
      FN_BLOCK_IDX: begin
        if (idx_ok) begin
          cmd.op = OP_BLOCK_IDX;
        end
      end
      FN_UNBLOCK: begin
        if (idx_ok) begin
          cmd.op = OP_UNBLOCK;
          cmd.sw = 1'b1;
        end
      end
      FN_SLEEP: begin
        cmd.op = OP_SLEEP;
        cmd.sw = 1'b1;
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

  assign req.ready = !fifo_st.full;
  assign push      = req.valid && !fifo_st.full;

endmodule

### hw/rtl/rpts_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue of decoded commands between the front end and the executor.
// ----------------------------------------------------------------------------
module rpts_fifo import rpts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cmd_t         wr_data,
  input  logic         pop,
  output cmd_t         rd_data,
  output fifo_status_t status
);

  cmd_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = count == FCNT_W'(FIFO_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

### hw/rtl/rpts_back.sv
// ----------------------------------------------------------------------------
// Scheduler executor
// Applies each command to the thread table, runs the sleep wake-up scan and
// the priority selection one thread per cycle, and registers the result.
// ----------------------------------------------------------------------------
module rpts_back import rpts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  fifo_status_t            fifo_st,
  input  cmd_t                    cmd,
  output logic                    pop,
  input  logic [PRIO_TABLE_W-1:0] prio_table,
  rpts_rsp_if.source              rsp,
  output logic                    idle
);

  back_state_t              bstate;
  back_state_t              bstate_next;
  cmd_t                     cmd_q;
  thread_state_t            thr_state   [MAX_THREADS];
  logic [MS_W-1:0]          sleep_start [MAX_THREADS];
  logic [MS_W-1:0]          sleep_delay [MAX_THREADS];
  logic [MS_W-1:0]          ms_clock;
  logic [TIDX_W-1:0]        running;
  logic [CNT_W-1:0]         scan;
  logic [TIDX_W-1:0]        sel;
  logic [PRIORITY_BITS-1:0] sel_prio;
  thread_state_t            sel_st;
  logic                     out_valid;
  logic [TIDX_W-1:0]        out_thread;
  logic [STATE_W-1:0]       out_state;
  logic                     out_switched;

  logic [TIDX_W-1:0]        rd_addr;
  thread_state_t            rd_st;
  logic [MS_W-1:0]          elapsed;
  logic [PRIORITY_BITS-1:0] cand_prio;
  logic                     last;
  logic                     runnable;
  logic                     better;
  logic                     wr_en;
  logic [TIDX_W-1:0]        wr_addr;
  thread_state_t            wr_val;
  logic                     sleep_wr;
  logic                     tick;
  logic                     load_out;

  always_comb begin
    case (bstate)
      BK_WAKE, BK_SELECT: rd_addr = scan[TIDX_W-1:0];
      default:            rd_addr = running;
    endcase
  end

  assign rd_st     = thr_state[rd_addr];
  assign elapsed   = ms_clock - sleep_start[rd_addr];
  assign cand_prio = prio_of(prio_table, rd_addr);
  assign last      = scan == cmd_q.n - 1'b1;
  assign runnable  = rd_st == ST_ACTIVE || rd_st == ST_PAUSED || rd_st == ST_QUEUED;
  assign better    = runnable && (cand_prio < sel_prio ||
                     (cand_prio == sel_prio && rd_st == ST_PAUSED && sel_st == ST_QUEUED));

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= BK_IDLE;
    end else begin
      bstate <= bstate_next;
    end
  end

  always_comb begin
    bstate_next = bstate;
    pop         = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = running;
    wr_val      = ST_PAUSED;
    sleep_wr    = 1'b0;
    tick        = 1'b0;
    load_out    = 1'b0;
    case (bstate)
      BK_IDLE: begin
        if (!fifo_st.empty) begin
          pop         = 1'b1;
          bstate_next = BK_APPLY;
        end
      end
      BK_APPLY: begin
        case (cmd_q.op)
          OP_TICK: begin
            tick = 1'b1;
          end
          OP_BLOCK_CUR: begin
            wr_en  = 1'b1;
            wr_val = ST_BLOCKED;
          end
          OP_BLOCK_IDX: begin
            wr_en   = 1'b1;
            wr_addr = cmd_q.idx;
            wr_val  = ST_BLOCKED;
          end
          OP_UNBLOCK: begin
            wr_en   = 1'b1;
            wr_addr = cmd_q.idx;
            wr_val  = ST_PAUSED;
          end
          OP_SLEEP: begin
            wr_en    = 1'b1;
            wr_val   = ST_SLEEPING;
            sleep_wr = 1'b1;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
        bstate_next = cmd_q.sw ? BK_WAKE : BK_REPORT;
      end
      BK_WAKE: begin
        if (rd_st == ST_SLEEPING && elapsed >= sleep_delay[rd_addr]) begin
          wr_en   = 1'b1;
          wr_addr = rd_addr;
        end
        if (last) begin
          bstate_next = BK_PAUSE;
        end
      end
      BK_PAUSE: begin
        if (rd_st == ST_ACTIVE) begin
          wr_en = 1'b1;
        end
        bstate_next = BK_SELECT;
      end
      BK_SELECT: begin
        if (last) begin
          bstate_next = BK_COMMIT;
        end
      end
      BK_COMMIT: begin
        wr_en       = 1'b1;
        wr_addr     = sel;
        wr_val      = ST_ACTIVE;
        bstate_next = BK_REPORT;
      end
      BK_REPORT: begin
        if (!out_valid || rsp.ready) begin
          load_out    = 1'b1;
          bstate_next = BK_IDLE;
        end
      end
      default: begin
        bstate_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        thr_state[i] <= (i == 0) ? ST_ACTIVE : ST_QUEUED;
      end
      ms_clock  <= '0;
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        thr_state[wr_addr] <= wr_val;
      end
      if (tick) begin
        ms_clock <= ms_clock + 1'b1;
      end
      if (bstate == BK_COMMIT) begin
        running <= sel;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_q <= cmd;
    end
    if (sleep_wr) begin
      sleep_start[running] <= ms_clock;
      sleep_delay[running] <= cmd_q.ms;
    end
    if (bstate == BK_APPLY || (bstate == BK_WAKE && last)) begin
      scan <= '0;
    end else if (bstate == BK_WAKE || bstate == BK_SELECT) begin
      scan <= scan + 1'b1;
    end
    if (bstate == BK_SELECT) begin
      if (scan == '0 || better) begin
        sel      <= rd_addr;
        sel_prio <= cand_prio;
        sel_st   <= rd_st;
      end
    end
    if (load_out) begin
      out_thread   <= running;
      out_state    <= rd_st;
      out_switched <= cmd_q.sw;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.current_thread = out_thread;
  assign rsp.current_state  = out_state;
  assign rsp.switched       = out_switched;
  assign idle               = bstate == BK_IDLE;

endmodule

### hw/rtl/rtos_priority_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Fixed-priority preemptive thread scheduler
// A switching request runs the wake-up and selection scans over the thread
// table, one thread a cycle, n the threads in use; other requests skip the
// scans. The executor takes a new request from the queue only once the result
// of the last is loaded. Synchronous reset: thread 0 active, others queued,
// clock and registers at their reset values, queue empty.
// ----------------------------------------------------------------------------
module rtos_priority_thread_scheduler import rpts_pkg::*; (
  input logic        clk,
  input logic        rst,
  rpts_req_if.sink   req,
  rpts_rsp_if.source rsp,
  rpts_cfg_if.sink   cfg
);

  logic                    enabled;
  logic [TC_W-1:0]         thread_count;
  logic [PRIO_TABLE_W-1:0] prio_table;
  fifo_status_t            fifo_st;
  logic                    push;
  logic                    pop;
  cmd_t                    push_cmd;
  cmd_t                    head_cmd;
  logic                    back_idle;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      thread_count <= TC_W'(1);
      prio_table   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ENABLE: enabled      <= cfg.data[0];
        CFG_COUNT:  thread_count <= cfg.data[TC_W-1:0];
        CFG_PRIO:   prio_table   <= cfg.data[PRIO_TABLE_W-1:0];
        default:    enabled      <= enabled;
      endcase
    end
  end

  rpts_front u_front (
    .req          (req),
    .enabled      (enabled),
    .thread_count (thread_count),
    .fifo_st      (fifo_st),
    .push         (push),
    .cmd          (push_cmd)
  );

  rpts_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_cmd),
    .pop     (pop),
    .rd_data (head_cmd),
    .status  (fifo_st)
  );

  rpts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_st    (fifo_st),
    .cmd        (head_cmd),
    .pop        (pop),
    .prio_table (prio_table),
    .rsp        (rsp),
    .idle       (back_idle)
  );

`ifndef NO_ASSERTIONS
  a_switch_active: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.switched |-> rsp.current_state == ST_ACTIVE)
    else $error("switched result does not report an active thread");

  a_back_starts: assert property (@(posedge clk) disable iff (rst)
    !fifo_st.empty && back_idle |=> !back_idle)
    else $error("executor did not take a queued request");

  a_fifo_status: assert property (@(posedge clk) disable iff (rst)
    !(fifo_st.full && fifo_st.empty))
    else $error("command queue both full and empty");
`endif

endmodule
